FILE: sv/rbf_kernel_evaluator_macros.svh
// Assertion macros shared by the rbf kernel evaluator modules.
`ifndef RBF_KERNEL_EVALUATOR_MACROS_SVH
`define RBF_KERNEL_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define RBF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbf assertion failed");

// ante implies cons in the next cycle
`define RBF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbf assertion failed");

`else

`define RBF_ASSERT_IMP(label, ante, cons)
`define RBF_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: sv/rbf_pkg.sv
// Shared types and constants of the rbf kernel evaluator.
package rbf_pkg;

  localparam int COORD_W  = 16;
  localparam int MAG_W    = 16;
  localparam int TERM_W   = 32;
  localparam int ACC_W    = 38;
  localparam int SCALE_W  = 32;
  localparam int KVAL_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // ln 2 in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 1'b1;

  localparam logic [SCALE_W-1:0] INVERSE_SCALE_RST = 32'd32768;

  // kernel modes
  localparam logic MODE_GAUSS   = 1'b0;
  localparam logic MODE_LAPLACE = 1'b1;

  // finished vector distance handed from front to back
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] dist_sum;
  } dist_req_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_ARG,
    BK_REDUCE,
    BK_TMUL,
    BK_TPREP,
    BK_TDIV,
    BK_ROUND,
    BK_DONE
  } bk_state_t;

endpackage

FILE: sv/rbf_front.sv
// Front end: distance term per coordinate pair and saturating accumulation.
module rbf_front #(
  parameter int DEPTH = rbf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [rbf_pkg::COORD_W-1:0]  coord_a,
  input  logic signed [rbf_pkg::COORD_W-1:0]  coord_b,
  input  logic                                last_coord,
  input  logic                                kernel_mode,
  input  logic [$clog2(DEPTH+1)-1:0]          level,
  output rbf_pkg::dist_req_t                  q_req
);
  import rbf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  // leave room for the two items in flight behind the input register
  localparam logic [CNT_W-1:0] LVL_STOP = CNT_W'(DEPTH - 2);

  logic                      accept;
  logic signed [COORD_W:0]   diff;
  logic [MAG_W-1:0]          mag;

  logic                      s1_valid;
  logic                      s1_last;
  logic                      s1_mode;
  logic [MAG_W-1:0]          s1_mag;

  logic                      s2_valid;
  logic                      s2_last;
  logic [TERM_W-1:0]         s2_term;

  logic [ACC_W-1:0]          acc;
  logic [ACC_W:0]            acc_sum;
  logic [ACC_W-1:0]          acc_sat;

  assign full   = (level >= LVL_STOP);
  assign accept = push && !full;

  assign diff = {coord_a[COORD_W-1], coord_a} - {coord_b[COORD_W-1], coord_b};
  assign mag  = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag  <= mag;
      s1_last <= last_coord;
      s1_mode <= kernel_mode;
    end
    s2_last <= s1_last;
    s2_term <= (s1_mode == MODE_LAPLACE) ? TERM_W'(s1_mag) : s1_mag * s1_mag;
  end

  assign acc_sum = {1'b0, acc} + (ACC_W+1)'(s2_term);
  assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= s2_last ? '0 : acc_sat;
    end
  end

  assign q_req.valid    = s2_valid && s2_last;
  assign q_req.dist_sum = acc_sat;

endmodule

FILE: sv/rbf_fifo.sv
// Short queue of finished distances between front and back end.
`include "rbf_kernel_evaluator_macros.svh"

module rbf_fifo #(
  parameter int DEPTH = rbf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rbf_pkg::dist_req_t            push_req,
  input  logic                          pop,
  output logic                          empty,
  output logic [rbf_pkg::ACC_W-1:0]     rd_dist,
  output logic [$clog2(DEPTH+1)-1:0]    level
);
  import rbf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [ACC_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push_req.valid) begin
      mem[wr_ptr] <= push_req.dist_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_req.valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_req.valid, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  assign empty   = (level == '0);
  assign rd_dist = mem[rd_ptr];

  `RBF_ASSERT_IMP(fifo_no_overflow, push_req.valid && !pop, level != CNT_W'(DEPTH))
  `RBF_ASSERT_IMP(fifo_no_underflow, pop, level != '0)

endmodule

FILE: sv/rbf_back.sv
// Back end: scaling, range reduction, Taylor series and rounding of exp(-arg).
`include "rbf_kernel_evaluator_macros.svh"

module rbf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [rbf_pkg::ACC_W-1:0]     q_dist,
  output logic                          q_pop,
  input  logic                          kernel_mode,
  input  logic [rbf_pkg::SCALE_W-1:0]   inverse_scale,
  output logic                          empty,
  input  logic                          pop,
  output logic [rbf_pkg::KVAL_W-1:0]    kernel_value,
  output logic [rbf_pkg::ACC_W-1:0]     distance
);
  import rbf_pkg::*;

  localparam logic [3:0] N_LAST  = 4'd12;
  localparam logic [4:0] K_TOP   = 5'd16;
  localparam logic [2:0] DIV_END = 3'd7;

  bk_state_t state, state_next;

  logic              out_valid;
  logic              out_load;

  logic [ACC_W-1:0]  dist_r;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_prod;
  logic [47:0]       pl_r;
  logic [62:0]       arg;
  logic              arg_big;
  logic [36:0]       rem_r;
  logic              rem_ge;
  logic [4:0]        k_cnt;
  logic [31:0]       r_r;
  logic [31:0]       term_r;
  logic [3:0]        n_cnt;
  logic signed [34:0] sum_r;
  logic [31:0]       div_word;
  logic [3:0]        div_rem;
  logic [2:0]        div_cnt;
  logic [3:0]        div_q;
  logic [3:0]        div_rem_new;
  logic [4:0]        trial;
  logic [31:0]       term_new;
  logic [KVAL_W-1:0] kval_r;
  logic [33:0]       e_pos;
  logic [34:0]       rnd_sum;
  logic [34:0]       rnd_shift;
  logic [KVAL_W-1:0] kval_round;

  // scaled argument, Q47.16
  always_comb begin
    if (kernel_mode == MODE_LAPLACE) begin
      arg = {1'b0, mul_prod[53:0], 8'b0} + 63'(pl_r[47:8]);
    end else begin
      arg = 63'(mul_prod[53:0]) + 63'(pl_r[47:16]);
    end
  end
  assign arg_big = |arg[62:21];
  assign rem_ge  = (rem_r >= 37'(LN2_Q32));

  // four quotient bits of the term division per cycle
  always_comb begin
    div_rem_new = div_rem;
    div_q       = '0;
    trial       = '0;
    for (int i = 0; i < 4; i++) begin
      trial = {div_rem_new, div_word[31-i]};
      if (trial >= {1'b0, n_cnt}) begin
        div_q[3-i]  = 1'b1;
        div_rem_new = 4'(trial - {1'b0, n_cnt});
      end else begin
        div_rem_new = trial[3:0];
      end
    end
  end
  assign term_new = {div_word[27:0], div_q};

  // e / 2^(k+16), rounded to nearest
  assign e_pos      = sum_r[34] ? '0 : sum_r[33:0];
  assign rnd_sum    = {1'b0, e_pos} + (35'(1) << (6'(k_cnt) + 6'd15));
  assign rnd_shift  = rnd_sum >> (6'(k_cnt) + 6'd16);
  assign kval_round = (|rnd_shift[34:16]) ? {KVAL_W{1'b1}} : rnd_shift[15:0];

  assign out_load = (state == BK_DONE) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_a      = term_r;
    mul_b      = r_r;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_MUL_LO;
        end
      end
      BK_MUL_LO: begin
        mul_a      = 32'(dist_r[15:0]);
        mul_b      = inverse_scale;
        state_next = BK_MUL_HI;
      end
      BK_MUL_HI: begin
        mul_a      = 32'(dist_r[ACC_W-1:16]);
        mul_b      = inverse_scale;
        state_next = BK_ARG;
      end
      BK_ARG:    state_next = arg_big ? BK_DONE : BK_REDUCE;
      BK_REDUCE: begin
        if (!rem_ge) begin
          state_next = BK_TMUL;
        end else if (k_cnt == K_TOP) begin
          state_next = BK_DONE;
        end
      end
      BK_TMUL:   state_next = BK_TPREP;
      BK_TPREP:  state_next = BK_TDIV;
      BK_TDIV: begin
        if (div_cnt == DIV_END) begin
          state_next = (n_cnt == N_LAST) ? BK_ROUND : BK_TMUL;
        end
      end
      BK_ROUND:  state_next = BK_DONE;
      BK_DONE: begin
        if (out_load) begin
          state_next = BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_prod <= 64'(mul_a) * 64'(mul_b);
    case (state)
      BK_IDLE:   dist_r <= q_dist;
      BK_MUL_HI: pl_r <= mul_prod[47:0];
      BK_ARG: begin
        rem_r  <= {arg[20:0], 16'b0};
        k_cnt  <= '0;
        kval_r <= '0;
      end
      BK_REDUCE: begin
        if (rem_ge) begin
          rem_r <= rem_r - 37'(LN2_Q32);
          k_cnt <= k_cnt + 1'b1;
        end else begin
          // first term folded in: t1 = r
          r_r    <= rem_r[31:0];
          term_r <= rem_r[31:0];
          sum_r  <= 35'sh1_0000_0000 - $signed({3'b0, rem_r[31:0]});
          n_cnt  <= 4'd2;
        end
      end
      BK_TPREP: begin
        div_word <= mul_prod[63:32];
        div_rem  <= '0;
        div_cnt  <= '0;
      end
      BK_TDIV: begin
        div_word <= term_new;
        div_rem  <= div_rem_new;
        div_cnt  <= div_cnt + 1'b1;
        if (div_cnt == DIV_END) begin
          term_r <= term_new;
          n_cnt  <= n_cnt + 1'b1;
          if (n_cnt[0]) begin
            sum_r <= sum_r - $signed({3'b0, term_new});
          end else begin
            sum_r <= sum_r + $signed({3'b0, term_new});
          end
        end
      end
      BK_ROUND:  kval_r <= kval_round;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kernel_value <= kval_r;
      distance     <= dist_r;
    end
  end

  assign empty = !out_valid;

  `RBF_ASSERT_IMP(bk_k_range, state == BK_REDUCE, k_cnt <= K_TOP)
  `RBF_ASSERT_NXT(bk_out_load, out_load, out_valid)
  `RBF_ASSERT_IMP(bk_pop_only_idle, q_pop, state == BK_IDLE && !q_empty)

endmodule

FILE: sv/rbf_kernel_evaluator.sv
// Top level of the Gaussian / Laplacian radial basis kernel evaluator.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  coords in | push / full        | coord_a, coord_b (Q8.8), last_coord
//  result    | pop / empty        | kernel_value (Q0.16), distance
//  config    | wr_en (no wait)    | wr_index, wr_data
//
// Coordinate requests are taken one per cycle while full is low; the front
// pipeline (difference, term multiply, saturating accumulate) is three registers deep.
// Each vector then passes through the back end: one shared 32x32 multiplier, 1 to 17
// range-reduction steps, and 11 Taylor terms, each a multiply, a load and eight
// 4-bit steps of the divide by n; a kernel flushed to zero, early or past the
// k cutoff, skips the series.
// full rises once DEPTH-2 finished distances wait in the queue; empty falls when
// the result register holds a request, and the back end stalls until it is popped.
// Synchronous reset clears the accumulator, the queue and the result register
// and returns the registers to Gaussian mode with scale 0.5; no clearing pass.
module rbf_kernel_evaluator #(
  parameter int QUEUE_DEPTH = rbf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // coordinate pairs
  input  logic                                push,
  output logic                                full,
  input  logic signed [rbf_pkg::COORD_W-1:0]  coord_a,
  input  logic signed [rbf_pkg::COORD_W-1:0]  coord_b,
  input  logic                                last_coord,
  // results
  output logic                                empty,
  input  logic                                pop,
  output logic [rbf_pkg::KVAL_W-1:0]          kernel_value,
  output logic [rbf_pkg::ACC_W-1:0]           distance,
  // register writes
  input  logic                                wr_en,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [rbf_pkg::SCALE_W-1:0]         wr_data
);
  import rbf_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic               kernel_mode;
  logic [SCALE_W-1:0] inverse_scale;

  dist_req_t          q_req;
  logic [CNT_W-1:0]   q_level;
  logic               q_empty;
  logic               q_pop;
  logic [ACC_W-1:0]   q_dist;

  // configuration registers; the user must write them only while the block is idle
  // (the block itself does not enforce it), so both halves read them live
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode   <= MODE_GAUSS;
      inverse_scale <= INVERSE_SCALE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KERNEL_MODE:   kernel_mode   <= wr_data[0];
        REG_INVERSE_SCALE: inverse_scale <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // accumulate |a-b| or (a-b)^2 per request, hand off the sum on the last one
  rbf_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .coord_a     (coord_a),
    .coord_b     (coord_b),
    .last_coord  (last_coord),
    .kernel_mode (kernel_mode),
    .level       (q_level),
    .q_req       (q_req)
  );

  // decouples the front, one request per cycle while not full, from the slow exponential
  rbf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_req (q_req),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_dist  (q_dist),
    .level    (q_level)
  );

  // exp(-distance*scale) with range reduction and a 13-term series
  rbf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_dist        (q_dist),
    .q_pop         (q_pop),
    .kernel_mode   (kernel_mode),
    .inverse_scale (inverse_scale),
    .empty         (empty),
    .pop           (pop),
    .kernel_value  (kernel_value),
    .distance      (distance)
  );

endmodule
